@@ rtl/bvkf_pkg.sv @@
package bvkf_pkg;

  localparam int AdcW   = 12;
  localparam int VoltW  = 24;
  localparam int CovW   = 32;
  localparam int PctW   = 11;
  localparam int WarmW  = 10;
  localparam int RepW   = 16;
  localparam int CfgIdxW = 3;
  localparam int CfgDatW = 32;

  localparam logic [CfgIdxW-1:0] REG_Q      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_R      = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SCALE  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SLOPE  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_OFFSET = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_WARMUP = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_INTVL  = 3'd6;

  // shift-add multiplier: 36-bit a times 32-bit b into a 68-bit product, one bit of b per cycle
  localparam int MulAW = 36;
  localparam int MulBW = 32;
  localparam int MulPW = MulAW + MulBW;

endpackage

@@ rtl/bvkf_mul.sv @@
// bit-serial unsigned multiplier, one multiplier bit per cycle
module bvkf_mul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [bvkf_pkg::MulAW-1:0]   a,
  input  logic [bvkf_pkg::MulBW-1:0]   b,
  output logic                         done,
  output logic [bvkf_pkg::MulPW-1:0]   prod
);
  logic [bvkf_pkg::MulPW-1:0] acc_r, acc_nxt;
  logic [bvkf_pkg::MulPW-1:0] mc_r, mc_nxt;
  logic [bvkf_pkg::MulBW-1:0] mp_r, mp_nxt;
  logic [5:0]                 cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;

  always_comb begin
    acc_nxt  = acc_r;
    mc_nxt   = mc_r;
    mp_nxt   = mp_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = '0;
      mc_nxt   = {{bvkf_pkg::MulBW{1'b0}}, a};
      mp_nxt   = b;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (mp_r[0]) acc_nxt = acc_r + mc_r;
      mc_nxt  = {mc_r[bvkf_pkg::MulPW-2:0], 1'b0};
      mp_nxt  = {1'b0, mp_r[bvkf_pkg::MulBW-1:1]};
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'(bvkf_pkg::MulBW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    mc_r  <= mc_nxt;
    mp_r  <= mp_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign prod = acc_r;
endmodule

@@ rtl/bvkf_div.sv @@
// restoring divider: floor(num * 2^24 / den), one quotient bit per cycle, 25 bits
module bvkf_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [32:0] num,
  input  logic [32:0] den,
  output logic        done,
  output logic [24:0] quo
);
  logic [33:0] rem_r, rem_nxt;
  logic [32:0] den_r, den_nxt;
  logic [24:0] q_r, q_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [33:0] trial;

  // num <= den always (num == den only when R is zero, handled by clamp), so 25 quotient bits suffice
  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[32:0], 1'b0};
    if (start) begin
      rem_nxt  = {1'b0, num};
      den_nxt  = den;
      q_nxt    = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      if (num >= den) begin
        rem_nxt = {1'b0, num - den};
        q_nxt   = 25'd1;
      end
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt   = {q_r[23:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[23:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd23) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quo  = q_r;
endmodule

@@ rtl/battery_voltage_kalman_filter.sv @@
// battery voltage estimator: scalar kalman filter on raw adc words
//
// input channel in_valid/in_ready carries one 12-bit adc word. each word
// gives exactly one result word on out_valid/out_ready: the filtered
// voltage (q4.20), a saturated percent, a report flag and a warming flag.
// the first warmup_samples words return warming=1 with other fields zero.
//
// one word is processed at a time. the work runs through a bit-serial
// shift-add multiplier (one multiplier bit per cycle) and a restoring
// divider (one quotient bit per cycle): scale, gain divide, estimate
// update, covariance update and percent product. out_valid rises once
// the last step is done (the covariance update for a warming word);
// in_ready returns the cycle after the result is taken.
//
// reset (synchronous, rst_n low) loads register defaults and clears the
// estimate, covariance and counters. a result waits in the output register
// while the receiver stalls; the next word is accepted only after the
// current result is taken. cfg_we writes register cfg_index at once.
module battery_voltage_kalman_filter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bvkf_pkg::AdcW-1:0]           in_adc_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bvkf_pkg::VoltW-1:0]          out_filtered_volts,
  output logic signed [bvkf_pkg::PctW-1:0]    out_percent,
  output logic                                out_report,
  output logic                                out_warming,
  input  logic                                cfg_we,
  input  logic [bvkf_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [bvkf_pkg::CfgDatW-1:0]        cfg_data
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SCALE = 9'b000000010,
    S_DIV   = 9'b000000100,
    S_EST   = 9'b000001000,
    S_COV   = 9'b000010000,
    S_PCT   = 9'b000100000,
    S_FIN   = 9'b001000000,
    S_OUT   = 9'b010000000,
    S_WAITD = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [31:0] q_r, r_r, offset_r;
  logic [23:0] scale_r, slope_r;
  logic [9:0]  warm_cfg_r;
  logic [15:0] intvl_r;

  // filter state
  logic [23:0] est_r, est_nxt;
  logic [31:0] cov_r, cov_nxt;
  logic [9:0]  warm_cnt_r, warm_cnt_nxt;
  logic [15:0] rep_cnt_r, rep_cnt_nxt;

  // working registers
  logic [23:0] v_r, v_nxt;
  logic [31:0] pp_r, pp_nxt;
  logic [23:0] k_r, k_nxt;

  // output register
  logic [23:0] o_volts_r, o_volts_nxt;
  logic [10:0] o_pct_r, o_pct_nxt;
  logic        o_rep_r, o_rep_nxt, o_warm_r, o_warm_nxt;

  // arithmetic units: multiplier shared by all products, divider for the gain
  logic                        mul_start;
  logic [bvkf_pkg::MulAW-1:0]  mul_a;
  logic [bvkf_pkg::MulBW-1:0]  mul_b;
  logic                        mul_done;
  logic [bvkf_pkg::MulPW-1:0]  mul_p;
  logic                        div_start, div_done;
  logic [32:0]                 div_num, div_den;
  logic [24:0]                 div_q;

  bvkf_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(mul_p)
  );

  bvkf_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_q)
  );

  logic [32:0] pp_sum, den_sum;
  logic        est_up;
  logic [23:0] est_diff;
  logic [67:0] off_sh;
  logic [67:0] pct_mag;
  logic        pct_neg;
  logic [31:0] pct_m;
  logic [24:0] one_minus_k;

  assign pp_sum      = {1'b0, cov_r} + {1'b0, q_r};
  assign den_sum     = {1'b0, pp_r} + {1'b0, r_r};
  assign est_up      = v_r >= est_r;
  assign est_diff    = est_up ? (v_r - est_r) : (est_r - v_r);
  assign off_sh      = {16'd0, offset_r, 20'd0};
  assign pct_neg     = mul_p < off_sh;
  assign pct_mag     = pct_neg ? (off_sh - mul_p) : (mul_p - off_sh);
  assign pct_m       = pct_mag[67:36];
  assign one_minus_k = 25'h1000000 - {1'b0, k_r};

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt    = state_r;
    est_nxt      = est_r;
    cov_nxt      = cov_r;
    warm_cnt_nxt = warm_cnt_r;
    rep_cnt_nxt  = rep_cnt_r;
    v_nxt        = v_r;
    pp_nxt       = pp_r;
    k_nxt        = k_r;
    o_volts_nxt  = o_volts_r;
    o_pct_nxt    = o_pct_r;
    o_rep_nxt    = o_rep_r;
    o_warm_nxt   = o_warm_r;
    mul_start    = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    div_start    = 1'b0;
    div_num      = {1'b0, pp_r};
    div_den      = den_sum;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mul_start  = 1'b1;
          mul_a      = {24'd0, in_adc_sample};
          mul_b      = {8'd0, scale_r};
          state_nxt  = S_SCALE;
        end
      end
      S_SCALE: begin
        if (mul_done) begin
          v_nxt  = (mul_p[67:28] != '0) ? 24'hFFFFFF : mul_p[27:4];
          pp_nxt = pp_sum[32] ? 32'hFFFFFFFF : pp_sum[31:0];
          state_nxt = S_WAITD;
        end
      end
      S_WAITD: begin
        // den_sum is zero only when pp and r are both zero
        if (den_sum == '0) begin
          k_nxt     = '0;
          mul_start = 1'b1;
          mul_a     = 36'd0;
          mul_b     = 32'(est_diff);
          state_nxt = S_EST;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          k_nxt     = div_q[24] ? 24'hFFFFFF : div_q[23:0];
          mul_start = 1'b1;
          mul_a     = div_q[24] ? 36'hFFFFFF : {12'd0, div_q[23:0]};
          mul_b     = 32'(est_diff);
          state_nxt = S_EST;
        end
      end
      S_EST: begin
        if (mul_done) begin
          if (est_up) est_nxt = est_r + mul_p[47:24];
          else        est_nxt = est_r - mul_p[47:24];
          mul_start = 1'b1;
          mul_a     = {11'd0, one_minus_k};
          mul_b     = pp_r;
          state_nxt = S_COV;
        end
      end
      S_COV: begin
        if (mul_done) begin
          cov_nxt = mul_p[55:24];
          if (warm_cnt_r < warm_cfg_r) begin
            warm_cnt_nxt = warm_cnt_r + 10'd1;
            o_volts_nxt  = '0;
            o_pct_nxt    = '0;
            o_rep_nxt    = 1'b0;
            o_warm_nxt   = 1'b1;
            state_nxt    = S_OUT;
          end else begin
            mul_start = 1'b1;
            mul_a     = {12'd0, est_r};
            mul_b     = {8'd0, slope_r};
            state_nxt = S_PCT;
          end
        end
      end
      S_PCT: begin
        if (mul_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (pct_neg) o_pct_nxt = (pct_m > 32'd1024) ? 11'h400 : 11'(-pct_m);
        else         o_pct_nxt = (pct_m > 32'd1023) ? 11'h3FF : pct_m[10:0];
        o_volts_nxt = est_r;
        o_warm_nxt  = 1'b0;
        if (rep_cnt_r + 16'd1 > intvl_r) begin
          rep_cnt_nxt = '0;
          o_rep_nxt   = 1'b1;
        end else begin
          rep_cnt_nxt = rep_cnt_r + 16'd1;
          o_rep_nxt   = 1'b0;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    v_r       <= v_nxt;
    pp_r      <= pp_nxt;
    k_r       <= k_nxt;
    o_volts_r <= o_volts_nxt;
    o_pct_r   <= o_pct_nxt;
    o_rep_r   <= o_rep_nxt;
    o_warm_r  <= o_warm_nxt;
    if (!rst_n) begin
      state_r    <= S_IDLE;
      est_r      <= '0;
      cov_r      <= '0;
      warm_cnt_r <= '0;
      rep_cnt_r  <= '0;
      q_r        <= 32'd16777;
      r_r        <= 32'd1677722;
      scale_r    <= 24'd13506;
      slope_r    <= 24'd1456356;
      offset_r   <= 32'd32039822;
      warm_cfg_r <= 10'd1000;
      intvl_r    <= 16'd60;
    end else begin
      state_r    <= state_nxt;
      est_r      <= est_nxt;
      cov_r      <= cov_nxt;
      warm_cnt_r <= warm_cnt_nxt;
      rep_cnt_r  <= rep_cnt_nxt;
      if (cfg_we) begin
        case (cfg_index)
          bvkf_pkg::REG_Q:      q_r        <= cfg_data;
          bvkf_pkg::REG_R:      r_r        <= cfg_data;
          bvkf_pkg::REG_SCALE:  scale_r    <= cfg_data[23:0];
          bvkf_pkg::REG_SLOPE:  slope_r    <= cfg_data[23:0];
          bvkf_pkg::REG_OFFSET: offset_r   <= cfg_data;
          bvkf_pkg::REG_WARMUP: warm_cfg_r <= cfg_data[9:0];
          bvkf_pkg::REG_INTVL:  intvl_r    <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

  assign out_filtered_volts = o_volts_r;
  assign out_percent        = o_pct_r;
  assign out_report         = o_rep_r;
  assign out_warming        = o_warm_r;

  // a warming word never carries a report
  a_warm_no_rep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_warming && out_report)) else $error("report during warmup");

  // in and out never both open
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready with pending result");

  // percent path reached only once the warmup counter meets the threshold register, unless a write raises it
  a_warm_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> (warm_cnt_r >= warm_cfg_r)) else $error("percent during warmup");

endmodule
